[design/ntdrw_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package ntdrw_pkg;

  // Display geometry and field widths
  localparam int MAX_DIGITS = 8;
  localparam int POS_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CFG_IDX_W  = 2;

  // Driver register addresses
  localparam logic [3:0] ADDR_DECODE     = 4'd9;
  localparam logic [3:0] ADDR_INTENSITY  = 4'd10;
  localparam logic [3:0] ADDR_SCAN_LIMIT = 4'd11;
  localparam logic [3:0] ADDR_SHUTDOWN   = 4'd12;

  // Control bytes and digit codes
  localparam logic [7:0] DECODE_ALL  = 8'hFF;
  localparam logic [7:0] WAKE_UP     = 8'h01;
  localparam logic [3:0] BLANK_CODE  = 4'hF;
  localparam logic [3:0] MAX_LEN     = 4'(MAX_DIGITS);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INTENSITY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_COUNT = 2'd1;

  // Commands
  localparam logic CMD_INIT = 1'b0;
  localparam logic CMD_SHOW = 1'b1;

  // Divide by ten: floor(q * RECIP10 / 2^RECIP_SHIFT) == q / 10 for any 32-bit q
  localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  typedef struct packed {
    logic        cmd;
    logic [31:0] value;
    logic [3:0]  decimal_places;
    logic [3:0]  field_length;
  } in_word_t;

  typedef struct packed {
    logic [3:0] reg_address;
    logic [7:0] reg_data;
    logic       last_write;
  } out_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT_DEC,
    S_INIT_INT,
    S_INIT_SCAN,
    S_INIT_SHUT,
    S_DIV,
    S_DIGIT
  } state_t;

  typedef enum logic [2:0] {
    EMIT_DECODE,
    EMIT_INTENSITY,
    EMIT_SCAN,
    EMIT_SHUTDOWN,
    EMIT_DIGIT
  } emit_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic      load;
    logic      mul;
    logic      emit_en;
    emit_sel_t emit_sel;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_show;
    logic in_len_zero;
    logic slot_free;
    logic last_digit;
  } dp_status_t;

endpackage
`default_nettype wire

[design/ntdrw_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module ntdrw_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_stall,
  input  ntdrw_pkg::dp_status_t sts,
  output ntdrw_pkg::ctl_cmd_t   cmd,
  output ntdrw_pkg::state_t     state
);
  import ntdrw_pkg::*;

  state_t state_next;

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (!sts.in_show) begin
            state_next = S_INIT_DEC;
          end else if (!sts.in_len_zero) begin
            state_next = S_DIV;
          end
        end
      end
      S_INIT_DEC: begin
        if (sts.slot_free) state_next = S_INIT_INT;
      end
      S_INIT_INT: begin
        if (sts.slot_free) state_next = S_INIT_SCAN;
      end
      S_INIT_SCAN: begin
        if (sts.slot_free) state_next = S_INIT_SHUT;
      end
      S_INIT_SHUT: begin
        if (sts.slot_free) state_next = S_IDLE;
      end
      S_DIV: begin
        state_next = S_DIGIT;
      end
      S_DIGIT: begin
        if (sts.slot_free) begin
          state_next = sts.last_digit ? S_IDLE : S_DIV;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_stall     = 1'b1;
    cmd.load     = 1'b0;
    cmd.mul      = 1'b0;
    cmd.emit_en  = 1'b0;
    cmd.emit_sel = EMIT_DIGIT;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_INIT_DEC: begin
        cmd.emit_en  = sts.slot_free;
        cmd.emit_sel = EMIT_DECODE;
      end
      S_INIT_INT: begin
        cmd.emit_en  = sts.slot_free;
        cmd.emit_sel = EMIT_INTENSITY;
      end
      S_INIT_SCAN: begin
        cmd.emit_en  = sts.slot_free;
        cmd.emit_sel = EMIT_SCAN;
      end
      S_INIT_SHUT: begin
        cmd.emit_en  = sts.slot_free;
        cmd.emit_sel = EMIT_SHUTDOWN;
      end
      S_DIV: begin
        cmd.mul = 1'b1;
      end
      S_DIGIT: begin
        cmd.emit_en  = sts.slot_free;
        cmd.emit_sel = EMIT_DIGIT;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule
`default_nettype wire

[design/ntdrw_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module ntdrw_dp (
  input  wire                                 clk,
  input  wire                                 rst,
  input  ntdrw_pkg::in_word_t                 in_data,
  input  wire                                 cfg_write,
  input  wire [ntdrw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [3:0]                           cfg_data,
  input  ntdrw_pkg::ctl_cmd_t                 cmd,
  output ntdrw_pkg::dp_status_t               sts,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output ntdrw_pkg::out_word_t                out_data
);
  import ntdrw_pkg::*;

  logic [3:0]       intensity;
  logic [3:0]       digit_count;
  logic [31:0]      q;
  logic [31:0]      quot;
  logic [3:0]       len;
  logic [3:0]       places;
  logic [POS_W-1:0] pos;

  logic [3:0]       in_len;
  logic [3:0]       in_places;
  logic [63:0]      prod;
  logic [3:0]       quot10_low;
  logic [3:0]       rem;
  logic [3:0]       dc_clamped;
  logic [3:0]       pos_ext;
  logic [3:0]       code;
  logic             point;
  out_word_t        word;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      intensity   <= 4'd7;
      digit_count <= MAX_LEN;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_INTENSITY:   intensity   <= cfg_data;
        CFG_DIGIT_COUNT: digit_count <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Clamp field length to the display and places to the field
  always_comb begin
    in_len    = (in_data.field_length > MAX_LEN) ? MAX_LEN : in_data.field_length;
    in_places = (in_data.decimal_places > in_len) ? in_len : in_data.decimal_places;
  end

  // Divide by ten through the reciprocal
  assign prod = {32'd0, q} * {32'd0, RECIP10};

  // Remainder needs only the low nibble: q - 10 * quot is below ten
  always_comb begin
    quot10_low = {quot[0], 3'b000} + {quot[2:0], 1'b0};
    rem        = q[3:0] - quot10_low;
  end

  // Load item, step quotient, advance position
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q      <= in_data.value;
      len    <= in_len;
      places <= in_places;
      pos    <= '0;
    end else if (cmd.mul) begin
      quot <= 32'(prod >> RECIP_SHIFT);
    end else if (cmd.emit_en && cmd.emit_sel == EMIT_DIGIT) begin
      q   <= quot;
      pos <= pos + POS_W'(1);
    end
  end

  // Digit code with blanking and decimal point
  always_comb begin
    pos_ext    = 4'(pos);
    dc_clamped = (digit_count == 4'd0) ? 4'd1 :
                 (digit_count > MAX_LEN) ? MAX_LEN : digit_count;
    code       = (pos_ext > places && q == 32'd0) ? BLANK_CODE : rem;
    point      = (pos_ext == places) && (places != 4'd0);
  end

  // Select the word to send
  always_comb begin
    word.last_write = 1'b0;
    case (cmd.emit_sel)
      EMIT_DECODE: begin
        word.reg_address = ADDR_DECODE;
        word.reg_data    = DECODE_ALL;
      end
      EMIT_INTENSITY: begin
        word.reg_address = ADDR_INTENSITY;
        word.reg_data    = {4'd0, intensity};
      end
      EMIT_SCAN: begin
        word.reg_address = ADDR_SCAN_LIMIT;
        word.reg_data    = {4'd0, dc_clamped - 4'd1};
      end
      EMIT_SHUTDOWN: begin
        word.reg_address = ADDR_SHUTDOWN;
        word.reg_data    = WAKE_UP;
        word.last_write  = 1'b1;
      end
      EMIT_DIGIT: begin
        word.reg_address = len - pos_ext;
        word.reg_data    = {point, 3'b000, code};
        word.last_write  = sts.last_digit;
      end
      default: begin
        word.reg_address = ADDR_SHUTDOWN;
        word.reg_data    = WAKE_UP;
      end
    endcase
  end

  // Output register: drop the word once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_en) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_en) begin
      out_data <= word;
    end
  end

  // Status
  always_comb begin
    sts.in_show     = (in_data.cmd == CMD_SHOW);
    sts.in_len_zero = (in_len == 4'd0);
    sts.slot_free   = !out_valid || !out_stall;
    sts.last_digit  = (pos_ext == len - 4'd1);
  end

endmodule
`default_nettype wire

[design/number_to_digit_register_writes_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Turns init and show commands into register writes for an eight-digit
// seven-segment display driver. One command is taken at a time: in_stall
// drops only while the block is idle. An init word gives four writes, one a
// cycle when the output is not stalled. A show word gives one write per
// digit position, rightmost first; each digit takes a divide-by-ten
// reciprocal multiply step and then a step that forms the digit and sends
// it, which waits while the output is stalled. A show word with a zero
// field length gives no writes. The last write sits in an output register,
// and a new command is taken while it waits. Configuration writes are always
// taken (cfg_ready is tied high) and should be made only while idle.
module number_to_digit_register_writes_core (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  ntdrw_pkg::in_word_t             in_data,
  output logic                            out_valid,
  input  wire                             out_stall,
  output ntdrw_pkg::out_word_t            out_data,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire [ntdrw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [3:0]                       cfg_data
);
  import ntdrw_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t sts;
  state_t     state;

  assign cfg_ready = 1'b1;

  ntdrw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd),
    .state    (state)
  );

  ntdrw_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // A word is never sent over one still waiting to be taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_en |-> sts.slot_free)
    else $error("write sent while output word still waiting");

  // A command that makes writes closes the input until it is done
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && !(sts.in_show && sts.in_len_zero)) |=> in_stall)
    else $error("input taken again before command finished");

  // The final digit write returns the controller to idle
  a_last_digit_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIGIT && cmd.emit_en && sts.last_digit) |=> (state == S_IDLE))
    else $error("controller busy after last digit");

  // The sent word carries the last mark exactly when the command ends
  a_last_mark: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_en |=> (out_data.last_write == (state == S_IDLE)))
    else $error("last write mark disagrees with controller");

endmodule
`default_nettype wire
